[rtl/core/gsig_pkg.sv]
package gsig_pkg;

	localparam int unsigned SEC_W = 8;
	localparam int unsigned IDX_W = 17;
	localparam int unsigned OUT_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_MINUS_ONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_SECTIONS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_MODE = 2'd2;

	localparam logic MODE_SERPENTINE = 1'b0;
	localparam logic MODE_TERRAIN = 1'b1;

	typedef enum logic [3:0] {
		PH_LOWER = 4'b0001,
		PH_UPPER = 4'b0010,
		PH_DEG1 = 4'b0100,
		PH_DEG2 = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [SEC_W-1:0] h;
		logic [SEC_W-1:0] v;
		logic mode;
	} cfg_t;

	typedef struct packed {
		logic [SEC_W-1:0] row;
		logic [IDX_W-1:0] base;
		logic [IDX_W-1:0] lower;
		phase_t phase;
	} gen_state_t;

	typedef struct packed {
		logic [OUT_W-1:0] idx;
		logic deg;
		logic last;
		logic empty;
	} result_t;

	localparam gen_state_t START_STATE = '{
		row: '0,
		base: '0,
		lower: '0,
		phase: PH_LOWER
	};

endpackage

[rtl/core/gsig_cfg.sv]
module gsig_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [gsig_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [gsig_pkg::CFG_DATA_W-1:0] cfg_data,
	output gsig_pkg::cfg_t cfg,
	output logic reload
);

	gsig_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.h <= gsig_pkg::SEC_W'(1);
			cfg_q.v <= gsig_pkg::SEC_W'(1);
			cfg_q.mode <= gsig_pkg::MODE_SERPENTINE;
		end else if (cfg_we) begin
			case (cfg_index)
				gsig_pkg::REG_COLUMNS_MINUS_ONE: cfg_q.h <= cfg_data[gsig_pkg::SEC_W-1:0];
				gsig_pkg::REG_ROW_SECTIONS: cfg_q.v <= cfg_data[gsig_pkg::SEC_W-1:0];
				gsig_pkg::REG_STRIP_MODE: cfg_q.mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Only writes to a real register send the generator back to the strip start.
	always_comb begin
		reload = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				gsig_pkg::REG_COLUMNS_MINUS_ONE,
				gsig_pkg::REG_ROW_SECTIONS,
				gsig_pkg::REG_STRIP_MODE: reload = 1'b1;
				default: reload = 1'b0;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/gsig_step.sv]
module gsig_step (
	input gsig_pkg::cfg_t cfg,
	input gsig_pkg::gen_state_t cur,
	input logic restart,
	output gsig_pkg::gen_state_t nxt,
	output gsig_pkg::result_t res
);

	gsig_pkg::gen_state_t st;
	logic [gsig_pkg::IDX_W-1:0] h_x;
	logic [gsig_pkg::IDX_W-1:0] c_x;
	logic [gsig_pkg::IDX_W-1:0] upper;
	logic [gsig_pkg::IDX_W-1:0] next_base;
	logic [gsig_pkg::SEC_W:0] row_p1;
	logic falling;
	logic row_done;
	gsig_pkg::gen_state_t next_row;

	always_comb begin
		st = restart ? gsig_pkg::START_STATE : cur;
		h_x = gsig_pkg::IDX_W'(cfg.h);
		c_x = h_x + gsig_pkg::IDX_W'(1);
		upper = st.lower + c_x;
		next_base = st.base + c_x;
		row_p1 = {1'b0, st.row} + (gsig_pkg::SEC_W + 1)'(1);
		falling = (cfg.mode == gsig_pkg::MODE_SERPENTINE) && st.row[0];
		row_done = falling ? (st.lower <= st.base) : (st.lower >= st.base + h_x);

		// Odd rows of a serpentine strip start at the right end of the row.
		next_row.row = row_p1[gsig_pkg::SEC_W-1:0];
		next_row.base = next_base;
		next_row.lower = (cfg.mode == gsig_pkg::MODE_SERPENTINE && row_p1[0]) ?
			next_base + h_x : next_base;
		next_row.phase = gsig_pkg::PH_LOWER;

		nxt = st;
		res.idx = '0;
		res.deg = 1'b0;
		res.last = 1'b0;
		res.empty = 1'b0;

		if (cfg.v == '0) begin
			nxt = gsig_pkg::START_STATE;
			res.last = 1'b1;
			res.empty = 1'b1;
		end else begin
			case (st.phase)
				gsig_pkg::PH_LOWER: begin
					res.idx = st.lower[gsig_pkg::OUT_W-1:0];
					nxt.phase = gsig_pkg::PH_UPPER;
				end
				gsig_pkg::PH_UPPER: begin
					res.idx = upper[gsig_pkg::OUT_W-1:0];
					if (!row_done) begin
						nxt.lower = falling ? st.lower - gsig_pkg::IDX_W'(1) :
							st.lower + gsig_pkg::IDX_W'(1);
						nxt.phase = gsig_pkg::PH_LOWER;
					end else if (row_p1 >= {1'b0, cfg.v}) begin
						res.last = 1'b1;
						nxt = gsig_pkg::START_STATE;
					end else begin
						nxt.phase = gsig_pkg::PH_DEG1;
					end
				end
				gsig_pkg::PH_DEG1: begin
					res.idx = upper[gsig_pkg::OUT_W-1:0];
					res.deg = 1'b1;
					if (cfg.mode == gsig_pkg::MODE_SERPENTINE) begin
						nxt = next_row;
					end else begin
						nxt.phase = gsig_pkg::PH_DEG2;
					end
				end
				gsig_pkg::PH_DEG2: begin
					res.idx = next_base[gsig_pkg::OUT_W-1:0];
					res.deg = 1'b1;
					nxt = next_row;
				end
				default: begin
					nxt = gsig_pkg::START_STATE;
				end
			endcase
		end
	end

endmodule

[rtl/core/grid_strip_index_generator.sv]
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   restart
// output    out        out_valid/out_stall vertex_index, is_degenerate, last_index, empty_strip
// config    in         cfg_we              cfg_index, cfg_data
//
// One request per cycle while in_stall is low: each accepted transfer yields its index in the
// output register in the next cycle, set by the single add/compare step from the strip state registers.
// Reset returns the config registers to their defaults and the strip to its start.
// A new request is taken whenever the output register is empty or being drained,
// so a stalled result holds while the input side waits.
module grid_strip_index_generator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic restart,
	output logic out_valid,
	input logic out_stall,
	output logic [gsig_pkg::OUT_W-1:0] vertex_index,
	output logic is_degenerate,
	output logic last_index,
	output logic empty_strip,
	input logic cfg_we,
	input logic [gsig_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [gsig_pkg::CFG_DATA_W-1:0] cfg_data
);

	gsig_pkg::cfg_t cfg;
	logic reload;
	gsig_pkg::gen_state_t state_q;
	gsig_pkg::gen_state_t state_nxt;
	gsig_pkg::result_t res;
	gsig_pkg::result_t res_q;
	logic out_valid_q;
	logic accept;

	gsig_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.reload(reload)
	);

	gsig_step u_step (
		.cfg(cfg),
		.cur(state_q),
		.restart(restart),
		.nxt(state_nxt),
		.res(res)
	);

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsig_pkg::START_STATE;
		end else if (reload) begin
			state_q <= gsig_pkg::START_STATE;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex_index = res_q.idx;
	assign is_degenerate = res_q.deg;
	assign last_index = res_q.last;
	assign empty_strip = res_q.empty;

	// An accepted request always produces a result in the next cycle.
	a_accept_yields_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted request produced no result");

	// A row link is never the final index of the strip.
	a_degenerate_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_degenerate && last_index))
		else $error("degenerate index flagged as last");

	// An empty grid reports a lone final index of zero.
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_strip) |-> (last_index && !is_degenerate && vertex_index == '0))
		else $error("malformed empty-strip result");

	// A register write puts the generator back at the strip start.
	a_reload_start: assert property (@(posedge clk) disable iff (!arst_n)
		reload |=> (state_q == gsig_pkg::START_STATE))
		else $error("register write did not restart the strip");

endmodule
